// ===== rtl/esd_pkg.sv =====
`timescale 1ns / 1ps

package esd_pkg;

  // decoder mode, one-hot
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_HEX1   = 4'b0100,
    MODE_HEX2   = 4'b1000
  } mode_t;

  // one decoded result for the output register
  typedef struct packed {
    logic       emit;
    logic       valid;
    logic       last;
    logic [7:0] data;
  } result_t;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
  localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] HEX_BASE       = 8'd16;

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // strtol-style base-16 parse of a two-character window, low byte
  function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] lo;
    logic [7:0] r;
    ha = hex_digit(a);
    hb = hex_digit(b);
    lo = {4'b0000, hb[3:0]};
    r  = 8'd0;
    if (is_space(a) || a == CHAR_PLUS) begin
      r = hb[4] ? lo : 8'd0;
    end else if (a == CHAR_MINUS) begin
      r = hb[4] ? 8'(8'd0 - lo) : 8'd0;
    end else if (ha[4]) begin
      r = hb[4] ? 8'({4'b0000, ha[3:0]} * HEX_BASE + lo) : {4'b0000, ha[3:0]};
    end
    return r;
  endfunction

  // {hit, byte} for a simple escape letter
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:          r = {1'b1, 8'h07};  // a
      8'h62:          r = {1'b1, 8'h08};  // b
      8'h66:          r = {1'b1, 8'h0C};  // f
      8'h6E:          r = {1'b1, 8'h0A};  // n
      8'h72:          r = {1'b1, 8'h0D};  // r
      8'h74:          r = {1'b1, 8'h09};  // t
      8'h76:          r = {1'b1, 8'h0B};  // v
      CHAR_BACKSLASH: r = {1'b1, CHAR_BACKSLASH};
      8'h3F:          r = {1'b1, 8'h3F};  // question mark
      8'h27:          r = {1'b1, 8'h27};  // single quote
      8'h22:          r = {1'b1, 8'h22};  // double quote
      8'h30:          r = {1'b1, 8'h00};  // zero
      default:        r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/esd_decode.sv =====
`timescale 1ns / 1ps

module esd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        in_char,
  input  logic              in_last,
  output esd_pkg::result_t  res
);

  esd_pkg::mode_t mode;
  esd_pkg::mode_t mode_next;
  logic [7:0]     first_hex;
  logic [7:0]     first_hex_next;
  logic           valid;
  logic [7:0]     data;
  logic [8:0]     esc;

  always_comb begin
    mode_next      = mode;
    first_hex_next = first_hex;
    valid          = 1'b0;
    data           = 8'd0;
    esc            = esd_pkg::simple_escape(in_char);
    unique case (mode)
      esd_pkg::MODE_NORMAL: begin
        if (in_char == esd_pkg::CHAR_BACKSLASH) begin
          mode_next = esd_pkg::MODE_ESCAPE;
        end else begin
          valid = 1'b1;
          data  = in_char;
        end
      end
      esd_pkg::MODE_ESCAPE: begin
        if (esc[8]) begin
          valid     = 1'b1;
          data      = esc[7:0];
          mode_next = esd_pkg::MODE_NORMAL;
        end else if (in_char == esd_pkg::CHAR_LOWER_X || in_char == esd_pkg::CHAR_UPPER_X) begin
          mode_next = esd_pkg::MODE_HEX1;
        end else begin
          // unknown escape drops the backslash
          valid     = 1'b1;
          data      = in_char;
          mode_next = esd_pkg::MODE_NORMAL;
        end
      end
      esd_pkg::MODE_HEX1: begin
        first_hex_next = in_char;
        mode_next      = esd_pkg::MODE_HEX2;
      end
      esd_pkg::MODE_HEX2: begin
        valid     = 1'b1;
        data      = esd_pkg::hex_pair(first_hex, in_char);
        mode_next = esd_pkg::MODE_NORMAL;
      end
      default: begin
        mode_next = esd_pkg::MODE_NORMAL;
      end
    endcase

    // final character flushes an open hex escape
    if (in_last) begin
      if (mode_next == esd_pkg::MODE_HEX1) begin
        valid = 1'b1;
        data  = 8'd0;
      end else if (mode_next == esd_pkg::MODE_HEX2) begin
        valid = 1'b1;
        data  = esd_pkg::hex_pair(first_hex_next, esd_pkg::CHAR_NUL);
      end
      mode_next = esd_pkg::MODE_NORMAL;
    end

    res.emit  = valid | in_last;
    res.valid = valid;
    res.last  = in_last;
    res.data  = valid ? data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= esd_pkg::MODE_NORMAL;
      first_hex <= 8'd0;
    end else if (advance) begin
      mode      <= mode_next;
      first_hex <= first_hex_next;
    end
  end

endmodule

// ===== rtl/escape_sequence_decoder.sv =====
`timescale 1ns / 1ps

// channel   | signals                          | beat contents
// ----------+----------------------------------+---------------------------------
// s_axis    | tvalid tready tdata tlast        | one escaped character, last flag
// m_axis    | tvalid tready tdata tuser tlast  | decoded byte, byte flag, last flag
//
// one character per cycle sustained unless the output stalls; from input beat to
// output beat: input register, then result register after the decode logic.
// rst is synchronous, clears the valid flags of both registers and the decoder mode.
// a character that decodes to nothing and is not last leaves no output beat;
// a stalled output holds the input register only when its item needs a beat.
module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [0:0] m_axis_tuser,   // [0] out_valid
  output logic       m_axis_tlast    // out_last
);

  logic             in_full;
  logic [7:0]       in_char;
  logic             in_last;
  logic             advance;
  esd_pkg::result_t res;

  // item leaves the input register when it needs no beat or the output has room
  assign advance       = in_full & (~res.emit | ~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_full | advance;

  esd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_char (in_char),
    .in_last (in_last),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && res.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_axis_tdata    <= res.data;
      m_axis_tuser[0] <= res.valid;
      m_axis_tlast    <= res.last;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 470;

  typedef struct {
    logic [7:0] ch;
    logic       flag;
    logic       lst;
  } decoded_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_char
  logic       s_axis_tlast;   // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_char
  logic [0:0] m_axis_tuser;   // [0] out_valid
  logic       m_axis_tlast;   // out_last

  // decoder state as the bench sees it
  esd_pkg::mode_t dec_mode;
  logic [7:0]     hex_first;

  decoded_t expected_bytes[$];
  int       errors;
  int       cycle_count;
  int       chars_sent;
  int       src_idle_pct;
  int       sink_stall_pct;
  logic     hold_request;

  escape_sequence_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- decoding

  function automatic int digit_value(input logic [7:0] c);
    if (c inside {["0":"9"]}) return int'(c) - int'("0");
    if (c inside {["a":"f"]}) return int'(c) - int'("a") + 10;
    if (c inside {["A":"F"]}) return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == esd_pkg::CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // base-16 strtol over a two-char window, low byte kept
  function automatic logic [7:0] strtol_low(input logic [7:0] a, input logic [7:0] b);
    int da;
    int db;
    int v;
    da = digit_value(a);
    db = digit_value(b);
    v = 0;
    if (da >= 0) begin
      v = (db >= 0) ? da * 16 + db : da;
    end else if (is_blank(a) || a == esd_pkg::CHAR_PLUS) begin
      v = (db >= 0) ? db : 0;
    end else if (a == esd_pkg::CHAR_MINUS) begin
      v = (db >= 0) ? 256 - db : 0;
    end
    return v[7:0];
  endfunction

  // -1 when c is not a one-letter escape
  function automatic int escape_code(input logic [7:0] c);
    case (c)
      "a":                     return 8'h07;
      "b":                     return 8'h08;
      "f":                     return 8'h0C;
      "n":                     return 8'h0A;
      "r":                     return 8'h0D;
      "t":                     return 8'h09;
      "v":                     return 8'h0B;
      "?":                     return 8'h3F;
      "0":                     return 8'h00;
      8'h27:                   return 8'h27;  // single quote
      8'h22:                   return 8'h22;  // double quote
      esd_pkg::CHAR_BACKSLASH: return esd_pkg::CHAR_BACKSLASH;
      default:                 return -1;
    endcase
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic last);
    decoded_t d;
    int       code;
    d.ch = 8'h00;
    d.flag = 1'b0;
    d.lst = last;
    case (dec_mode)
      esd_pkg::MODE_ESCAPE: begin
        code = escape_code(c);
        if (code >= 0) begin
          d.ch = code[7:0];
          d.flag = 1'b1;
          dec_mode = esd_pkg::MODE_NORMAL;
        end else if (c == esd_pkg::CHAR_LOWER_X || c == esd_pkg::CHAR_UPPER_X) begin
          dec_mode = esd_pkg::MODE_HEX1;
        end else begin
          // unknown escape: backslash dropped, char passes through
          d.ch = c;
          d.flag = 1'b1;
          dec_mode = esd_pkg::MODE_NORMAL;
        end
      end
      esd_pkg::MODE_HEX1: begin
        hex_first = c;
        dec_mode = esd_pkg::MODE_HEX2;
      end
      esd_pkg::MODE_HEX2: begin
        d.ch = strtol_low(hex_first, c);
        d.flag = 1'b1;
        dec_mode = esd_pkg::MODE_NORMAL;
      end
      default: begin
        if (c == esd_pkg::CHAR_BACKSLASH) begin
          dec_mode = esd_pkg::MODE_ESCAPE;
        end else begin
          d.ch = c;
          d.flag = 1'b1;
        end
      end
    endcase
    // final char flushes an open hex escape
    if (last) begin
      if (dec_mode == esd_pkg::MODE_HEX1) begin
        d.ch = 8'h00;
        d.flag = 1'b1;
      end else if (dec_mode == esd_pkg::MODE_HEX2) begin
        d.ch = strtol_low(hex_first, 8'h00);
        d.flag = 1'b1;
      end
      dec_mode = esd_pkg::MODE_NORMAL;
    end
    if (d.flag || last) expected_bytes.push_back(d);
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    decoded_t exp_byte;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected beat: out_char %02h out_valid %0b out_last %0b",
               m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        errors++;
      end else begin
        exp_byte = expected_bytes.pop_front();
        if (m_axis_tdata !== exp_byte.ch) begin
          $error("out_char: expected %02h, actual %02h", exp_byte.ch, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== exp_byte.flag) begin
          $error("out_valid: expected %0b, actual %0b", exp_byte.flag, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tlast !== exp_byte.lst) begin
          $error("out_last: expected %0b, actual %0b", exp_byte.lst, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("escape_sequence_decoder: mismatch");
      $finish;
    end
  end

  // output side: random stalls, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last);
    // each cycle is idle with the given odds
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    decode_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == esd_pkg::CHAR_BACKSLASH);
    return c;
  endfunction

  function automatic logic [7:0] pick_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (escape_code(c) >= 0 || c == esd_pkg::CHAR_LOWER_X || c == esd_pkg::CHAR_UPPER_X);
    return c;
  endfunction

  function automatic logic [7:0] pick_hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return digits[$urandom_range(digits.len() - 1)];
      5:             return esd_pkg::CHAR_PLUS;
      6:             return esd_pkg::CHAR_MINUS;
      7:             return ($urandom_range(1)) ? esd_pkg::CHAR_SPACE
                                                : 8'($urandom_range(9, 13));
      default:       return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic test_char_extremes();
    // lowest and highest char, then a lone backslash ends the string
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(esd_pkg::CHAR_BACKSLASH, 1'b1);
    wait_drained();
  endtask

  task automatic test_unknown_escape();
    send_text("\\q\\n");
    wait_drained();
  endtask

  task automatic test_hex_escapes();
    send_char(esd_pkg::CHAR_BACKSLASH, 1'b0);
    send_char(esd_pkg::CHAR_LOWER_X, 1'b0);
    send_text("Af\\X-5\\x+g");
    wait_drained();
  endtask

  task automatic test_short_hex();
    send_text("\\x7");
    send_text("\\x");
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [7:0] frame[$];
    int         target;
    int         tokens;
    int         cut;
    string      esc_letters;
    esc_letters = "abfnrtv\\?'\"0";
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    target = chars_sent + RANDOM_ITEMS;
    while (chars_sent < target) begin
      frame.delete();
      if ($urandom_range(9) == 0) begin
        // noise: raw chars, backslashes included
        repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(1, 255)));
      end else begin
        tokens = $urandom_range(1, 12);
        repeat (tokens) begin
          case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: frame.push_back(pick_plain());
            8, 9, 10, 11: begin
              frame.push_back(esd_pkg::CHAR_BACKSLASH);
              frame.push_back(esc_letters[$urandom_range(11)]);
            end
            12, 13, 14, 15, 16: begin
              frame.push_back(esd_pkg::CHAR_BACKSLASH);
              frame.push_back(($urandom_range(1)) ? esd_pkg::CHAR_LOWER_X
                                                  : esd_pkg::CHAR_UPPER_X);
              frame.push_back(pick_hex_char());
              frame.push_back(pick_hex_char());
            end
            default: begin
              frame.push_back(esd_pkg::CHAR_BACKSLASH);
              frame.push_back(pick_unknown());
            end
          endcase
        end
        // broken frame: cut it short, possibly inside an escape
        if ($urandom_range(9) == 0 && frame.size() > 1) begin
          cut = $urandom_range(1, frame.size() - 1);
          repeat (cut) void'(frame.pop_back());
        end
      end
      foreach (frame[i]) send_char(frame[i], i == frame.size() - 1);
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) send_char(pick_plain(), i == 59);
    wait_drained();
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    chars_sent = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_request = 1'b0;
    dec_mode = esd_pkg::MODE_NORMAL;
    hex_first = 8'h00;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_char_extremes();
    test_unknown_escape();
    test_hex_escapes();
    test_short_hex();
    test_random_traffic(0, 0);
    test_random_traffic(56, 0);
    test_random_traffic(0, 56);
    test_random_traffic(12, 12);
    test_output_backpressure();

    if (errors == 0) begin
      $display("escape_sequence_decoder: match");
    end else begin
      $display("escape_sequence_decoder: mismatch");
    end
    $finish;
  end

endmodule
